>>> rtl/frc_pkg.sv
// ----------------------------------------------------------------------------
// Fuel and speed rate calculator package
// Shared types, constants and codes for the trip computer rate block.
// ----------------------------------------------------------------------------
`default_nettype none

package frc_pkg;

	// Field widths
	localparam int unsigned MODE_W  = 2;
	localparam int unsigned DATA_W  = 16;
	localparam int unsigned SUM_W   = 32;
	localparam int unsigned PROD_W  = SUM_W + DATA_W;
	localparam int unsigned CFG_IDX_W = 2;

	// Item modes
	localparam logic [MODE_W-1:0] MODE_FUEL  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SPEED = 2'd1;
	localparam logic [MODE_W-1:0] MODE_STEP  = 2'd2;

	// Register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_FUEL_SCALE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INJECTION_SCALE = 2'd2;

	// Register reset values
	localparam logic [DATA_W-1:0] FUEL_SCALE_RST      = 16'd7;
	localparam logic [DATA_W-1:0] SPEED_SCALE_RST     = 16'd0;
	localparam logic [DATA_W-1:0] INJECTION_SCALE_RST = 16'd524;

	// Consumption factor: 100 in 8.8 format
	localparam logic [DATA_W-1:0] LP100_FACTOR = 16'(100 << 8);
	localparam logic [DATA_W-1:0] SAT16        = 16'hFFFF;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_INJ,
		S_LPH,
		S_KPH,
		S_LP,
		S_DIVST,
		S_DIV,
		S_DONE
	} state_t;

	// Divider request and status
	typedef struct packed {
		logic              start;
		logic [SUM_W-1:0]  num;
		logic [DATA_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DATA_W-1:0] quo;
	} div_sts_t;

	// Saturate the 8.8 scaled product to 16 bits
	function automatic logic [DATA_W-1:0] sat_scaled(input logic [PROD_W-1:0] p);
		logic [DATA_W-1:0] r;
		if (|p[PROD_W-1:2*8+DATA_W-8]) begin
			r = SAT16;
		end else begin
			r = p[DATA_W+7:8];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/frc_in_if.sv
// ----------------------------------------------------------------------------
// Input channel
// Carries one event or step tick word with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface frc_in_if import frc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [DATA_W-1:0] amount;
	logic              second_boundary;

	modport source (output valid, output mode, output amount, output second_boundary,
		input ready);
	modport sink (input valid, input mode, input amount, input second_boundary,
		output ready);
endinterface

`default_nettype wire

>>> rtl/frc_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Carries one rate result word with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface frc_out_if import frc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] injection_ms;
	logic              rates_valid;
	logic [DATA_W-1:0] litres_per_hour;
	logic [DATA_W-1:0] speed_kph;
	logic [DATA_W-1:0] litres_per_100km;

	modport source (output valid, output injection_ms, output rates_valid,
		output litres_per_hour, output speed_kph, output litres_per_100km, input ready);
	modport sink (input valid, input injection_ms, input rates_valid,
		input litres_per_hour, input speed_kph, input litres_per_100km, output ready);
endinterface

`default_nettype wire

>>> rtl/frc_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface frc_cfg_if import frc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/frc_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// One 32 by 16 bit unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module frc_mul import frc_pkg::*; (
	input  wire logic              clk,
	input  wire logic [SUM_W-1:0]  a,
	input  wire logic [DATA_W-1:0] b,
	output logic [PROD_W-1:0]      p_q
);

	// Product register, read by the sequencer in the cycle after the operands.
	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

`default_nettype wire

>>> rtl/frc_div.sv
// ----------------------------------------------------------------------------
// Consumption divider
// Restoring divider, one quotient bit per cycle, saturating at 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module frc_div import frc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_sts_t      sts
);

	localparam int unsigned CNT_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic              sat_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] den_q;
	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   diff;
	logic              take;

	// One restoring step: shift in the next dividend bit and try to subtract.
	always_comb begin
		trial = {rem_q, quo_q[DATA_W-1]};
		diff  = trial - {1'b0, den_q};
		take  = (trial >= {1'b0, den_q});
	end

	// Control: busy while the steps run, done pulses after the last step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: a quotient of 2^16 or more is caught up front as saturation,
	// so the upper dividend half seeds the remainder directly.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[SUM_W-1:DATA_W];
			quo_q <= req.num[DATA_W-1:0];
			den_q <= req.den;
			sat_q <= (req.num[SUM_W-1:DATA_W] >= req.den);
		end else if (busy_q) begin
			rem_q <= take ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			quo_q <= {quo_q[DATA_W-2:0], take};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign sts.quo  = sat_q ? SAT16 : quo_q;

endmodule

`default_nettype wire

>>> rtl/fuel_speed_rate_calculator.sv
// ----------------------------------------------------------------------------
// Fuel and speed rate calculator
// Trip computer rate block: step and second sums, injection time and rates.
// ----------------------------------------------------------------------------
// Usage:
//   item   - input words: fuel event, speed event or step tick (mode field).
//   result - one result word per step tick; events and unused modes give none.
//   cfg    - register writes, always ready; write only while the block is idle.
// Sequencing and throughput:
//   Fuel and speed events are absorbed in the cycle they are accepted, so
//   events can arrive back to back.
//   A step tick without a second boundary runs two multiplier passes worth
//   of sequencing (S_INJ, S_LPH), then loads the result in S_DONE.
//   A step tick on a second boundary runs four passes of the shared 32x16
//   multiplier and then, unless the speed is zero, the one-bit-per-cycle
//   divider before the result register is loaded.
//   The input is not ready while a step tick is in progress.
// Reset and stall:
//   Reset loads the scale registers with their defaults and clears all sums.
//   A finished result sits in the output register until taken; the block
//   accepts further items meanwhile and only waits when the next result is
//   ready to be written.
// ----------------------------------------------------------------------------
`default_nettype none

module fuel_speed_rate_calculator import frc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	frc_in_if.sink    item,
	frc_out_if.source result,
	frc_cfg_if.sink   cfg
);

	state_t            state_q, state_d;

	logic [DATA_W-1:0] fuel_scale_q, speed_scale_q, injection_scale_q;
	logic [DATA_W-1:0] step_fuel_q, last_inj_q, step_speed_q;
	logic [SUM_W-1:0]  sec_fuel_q;
	logic [DATA_W-1:0] sec_speed_q;
	logic              bnd_q;
	logic [DATA_W-1:0] inj_q, lph_q, kph_q, lp100_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_inj_q, out_lph_q, out_kph_q, out_lp100_q;
	logic              out_rv_q;

	logic              accept;
	logic              load_out;
	logic [SUM_W-1:0]  mul_a;
	logic [DATA_W-1:0] mul_b;
	logic [PROD_W-1:0] prod_q;
	div_req_t          div_req;
	div_sts_t          div_sts;

	// Shared multiplier and divider
	frc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	frc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.sts    (div_sts)
	);

	assign accept    = item.valid && item.ready;
	assign cfg.ready = 1'b1;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, multiplier operand selection and divider start
	always_comb begin
		state_d     = state_q;
		item.ready  = 1'b0;
		mul_a       = '0;
		mul_b       = '0;
		load_out    = 1'b0;
		div_req.start = 1'b0;
		div_req.num   = prod_q[SUM_W-1:0];
		div_req.den   = kph_q;
		unique case (state_q)
			S_IDLE: begin
				item.ready = 1'b1;
				if (item.valid && item.mode == MODE_STEP) begin
					state_d = S_INJ;
				end
			end
			S_INJ: begin
				mul_a   = SUM_W'(last_inj_q);
				mul_b   = injection_scale_q;
				state_d = S_LPH;
			end
			S_LPH: begin
				mul_a   = sec_fuel_q;
				mul_b   = fuel_scale_q;
				state_d = bnd_q ? S_KPH : S_DONE;
			end
			S_KPH: begin
				mul_a   = SUM_W'(sec_speed_q);
				mul_b   = speed_scale_q;
				state_d = S_LP;
			end
			S_LP: begin
				mul_a   = SUM_W'(lph_q);
				mul_b   = LP100_FACTOR;
				state_d = S_DIVST;
			end
			S_DIVST: begin
				if (kph_q != '0) begin
					div_req.start = 1'b1;
					state_d       = S_DIV;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DIV: begin
				if (div_sts.done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || result.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fuel_scale_q      <= FUEL_SCALE_RST;
			speed_scale_q     <= SPEED_SCALE_RST;
			injection_scale_q <= INJECTION_SCALE_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_FUEL_SCALE:      fuel_scale_q      <= cfg.data;
				REG_SPEED_SCALE:     speed_scale_q     <= cfg.data;
				REG_INJECTION_SCALE: injection_scale_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Step and second sums. A step tick folds the step sums in at accept;
	// the last injection is cleared once the multiplier has read it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_fuel_q  <= '0;
			last_inj_q   <= '0;
			step_speed_q <= '0;
			sec_fuel_q   <= '0;
			sec_speed_q  <= '0;
			bnd_q        <= 1'b0;
		end else begin
			if (accept) begin
				case (item.mode)
					MODE_FUEL: begin
						step_fuel_q <= step_fuel_q + item.amount;
						last_inj_q  <= item.amount;
					end
					MODE_SPEED: begin
						step_speed_q <= step_speed_q + item.amount;
					end
					MODE_STEP: begin
						sec_fuel_q   <= sec_fuel_q + SUM_W'(step_fuel_q);
						sec_speed_q  <= sec_speed_q + step_speed_q;
						step_fuel_q  <= '0;
						step_speed_q <= '0;
						bnd_q        <= item.second_boundary;
					end
					default: ;
				endcase
			end
			if (state_q == S_INJ) begin
				last_inj_q <= '0;
			end
			if (load_out && bnd_q) begin
				sec_fuel_q  <= '0;
				sec_speed_q <= '0;
			end
		end
	end

	// Result fields, captured from the multiplier and divider in turn
	always_ff @(posedge clk) begin
		if (accept) begin
			lph_q   <= '0;
			kph_q   <= '0;
			lp100_q <= '0;
		end
		case (state_q)
			S_LPH:   inj_q   <= prod_q[DATA_W+7:8];
			S_KPH:   lph_q   <= sat_scaled(prod_q);
			S_LP:    kph_q   <= sat_scaled(prod_q);
			S_DIV:   lp100_q <= div_sts.quo;
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_inj_q   <= inj_q;
			out_rv_q    <= bnd_q;
			out_lph_q   <= lph_q;
			out_kph_q   <= kph_q;
			out_lp100_q <= lp100_q;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.injection_ms     = out_inj_q;
	assign result.rates_valid      = out_rv_q;
	assign result.litres_per_hour  = out_lph_q;
	assign result.speed_kph        = out_kph_q;
	assign result.litres_per_100km = out_lp100_q;

`ifndef SYNTH
	// A step tick always starts the sequencer on the injection pass.
	a_step_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.mode == MODE_STEP |=> state_q == S_INJ)
		else $error("step tick did not start the sequencer");

	// The divider is never started with a zero speed.
	a_div_den: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> div_req.den != '0)
		else $error("divider started with zero divisor");

	// The divider is idle whenever the block takes new words.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !div_sts.busy)
		else $error("divider busy while sequencer idle");

	// Without a second boundary all rate fields are zero.
	a_no_rates: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.rates_valid |-> result.litres_per_hour == '0
		&& result.speed_kph == '0 && result.litres_per_100km == '0)
		else $error("rate fields set without second boundary");
`endif

endmodule

`default_nettype wire
